// File: sv/fbrb_pkg.sv
package fbrb_pkg;

   localparam int DEFAULT_RING_BYTES = 1024;
   localparam int BYTE_W             = 8;
   localparam int LEN_W              = 11;
   localparam int KIND_W             = 2;
   localparam int DROP_W             = 32;
   localparam int USED_W             = 11;
   localparam int HDR_BYTES          = 4;
   localparam int HDR_W              = HDR_BYTES * BYTE_W;
   localparam int QUEUE_DEPTH        = 2;   // power of two, pointers wrap naturally

   localparam int REQ_DATA_W = ((LEN_W + BYTE_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = BYTE_W + 1 + DROP_W + USED_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [DROP_W-1:0] DROP_MAX = '1;

   // request kind codes on req_tuser
   localparam logic [KIND_W-1:0] KIND_OPEN    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TAKE    = 2'd2;

   typedef enum logic [1:0] {
      OP_OPEN,
      OP_PAYLOAD,
      OP_TAKE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [LEN_W-1:0]    len;
      logic [BYTE_W-1:0]   data;
   } item_type;

   typedef struct packed {
      logic [USED_W-1:0]   bytes_used;
      logic [DROP_W-1:0]   drop_count;
      logic                accepted;
      logic                record_end;
      logic                byte_valid;
      logic [BYTE_W-1:0]   out_byte;
   } result_type;

endpackage

// File: sv/framed_byte_ring_buffer_unit.sv
// Framed byte ring buffer: a byte ring of RING_BYTES holding variable-length
// records, each stored behind a 4-byte little-endian length header.
// Request channel (req_*): req_tuser carries the kind (open, payload, take);
// req_tdata carries the record length (open) and the payload byte (payload).
// Response channel (rsp_*): exactly one response per request, in order.
// A take returns the next committed payload byte, rsp_tlast marks the last
// byte of a record; status (accepted, drop count, bytes used) rides along.
// Back-end steps per request, set by the single-port byte memory:
//   payload, rejected open, empty take, unknown kind: decode, then respond
//   take inside a record: one registered memory read
//   accepted open: four header byte writes
//   take at a record start: four header reads, check, payload read
//   take that finds a corrupt header: four header reads and check, no payload read
// The front keeps taking requests while the two-entry request queue has room,
// so behind a stalled response up to three more requests get in (one in the
// back end, two queued) before req_tready drops.
// A held response sits in the output register; the back end waits for it.
// Reset (synchronous, active high) empties the ring, the queue and the
// output register and clears the drop count; the ring memory is not cleared.
module framed_byte_ring_buffer_unit import fbrb_pkg::*; #(
   parameter int RING_BYTES = DEFAULT_RING_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // record_length, data_byte
   input  logic [KIND_W-1:0]     req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte, accepted, drop_count, bytes_used
   output logic                  rsp_tuser,   // byte_valid
   output logic                  rsp_tlast    // record_end
);

   item_type   q_item;
   logic       q_valid;
   logic       q_pop;
   result_type result;

   // front end: accept and classify into a short queue
   fbrb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // back end: ring memory, record bookkeeping and response register
   fbrb_back #(
      .RING_BYTES (RING_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // pack response fields, lowest first, zero filled to whole bytes
   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELD_W)'(0),
                       result.bytes_used,
                       result.drop_count,
                       result.accepted,
                       result.out_byte};
   assign rsp_tuser = result.byte_valid;
   assign rsp_tlast = result.record_end;

endmodule

// File: sv/fbrb_front.sv
module fbrb_front import fbrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  q_valid,
   output item_type              q_item,
   input  logic                  q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   item_type            new_item;
   logic                push, pop;

   // classify the incoming request
   always_comb begin
      new_item.len  = req_tdata[LEN_W-1:0];
      new_item.data = req_tdata[LEN_W +: BYTE_W];
      case (req_tuser)
         KIND_OPEN:    new_item.op = OP_OPEN;
         KIND_PAYLOAD: new_item.op = OP_PAYLOAD;
         KIND_TAKE:    new_item.op = OP_TAKE;
         default:      new_item.op = OP_NONE;
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue over depth");

   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(QUEUE_DEPTH)) && !pop |=> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("queue count moved while full");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointer gap");

endmodule

// File: sv/fbrb_back.sv
module fbrb_back import fbrb_pkg::*; #(
   parameter int RING_BYTES = DEFAULT_RING_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   localparam int AW    = $clog2(RING_BYTES);
   localparam int CW    = $clog2(RING_BYTES + 1);
   localparam int CNT_W = $clog2(HDR_BYTES + 1);
   localparam int CMP_W = ((CW > LEN_W + 1) ? CW : LEN_W + 1) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPEN_HDR,
      ST_HDR,
      ST_CHK,
      ST_TAKE_WAIT,
      ST_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       write_head_ff, write_head_in;
   logic [AW-1:0]       read_tail_ff, read_tail_in;
   logic                ring_full_ff, ring_full_in;
   logic [AW-1:0]       write_cursor_ff, write_cursor_in;
   logic [LEN_W-1:0]    write_remaining_ff, write_remaining_in;
   logic                write_open_ff, write_open_in;
   logic                write_discard_ff, write_discard_in;
   logic [CW-1:0]       read_remaining_ff, read_remaining_in;
   logic [DROP_W-1:0]   drops_ff, drops_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [HDR_W-1:0]    hl_ff, hl_in;
   logic [BYTE_W-1:0]   res_byte_ff, res_byte_in;
   logic                res_valid_ff, res_valid_in;
   logic                res_end_ff, res_end_in;
   logic                res_acc_ff, res_acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   logic [BYTE_W-1:0]   ring_mem [RING_BYTES];
   logic [BYTE_W-1:0]   rd_data_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [BYTE_W-1:0]   mem_wdata;

   logic [CW-1:0]       used;
   logic [CMP_W-1:0]    need, free_bytes;
   logic                reject;
   logic [LEN_W-1:0]    rem_dec;
   logic [AW-1:0]       cursor_next;
   logic [CW-1:0]       rr_dec;
   logic [1:0]          drop_n;
   logic [DROP_W:0]     drop_sum;
   logic [HDR_W-1:0]    hdr_word;

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
      next_pos = (p == AW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   // committed bytes, headers included
   always_comb begin
      if (ring_full_ff) begin
         used = CW'(RING_BYTES);
      end else if (write_head_ff >= read_tail_ff) begin
         used = CW'(write_head_ff) - CW'(read_tail_ff);
      end else begin
         used = CW'(RING_BYTES) - (CW'(read_tail_ff) - CW'(write_head_ff));
      end
   end

   assign need       = CMP_W'(q_item.len) + CMP_W'(HDR_BYTES);
   assign free_bytes = CMP_W'(RING_BYTES) - CMP_W'(used);
   assign reject     = (q_item.len == '0) || (need > free_bytes);
   assign rem_dec    = (write_remaining_ff != '0) ? write_remaining_ff - 1'b1
                                                  : write_remaining_ff;
   assign cursor_next = next_pos(write_cursor_ff);
   assign rr_dec     = read_remaining_ff - 1'b1;
   assign hdr_word   = HDR_W'(write_remaining_ff);
   assign q_pop      = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_comb begin
      state_in           = state_ff;
      write_head_in      = write_head_ff;
      read_tail_in       = read_tail_ff;
      ring_full_in       = ring_full_ff;
      write_cursor_in    = write_cursor_ff;
      write_remaining_in = write_remaining_ff;
      write_open_in      = write_open_ff;
      write_discard_in   = write_discard_ff;
      read_remaining_in  = read_remaining_ff;
      cnt_in             = cnt_ff;
      hl_in              = hl_ff;
      res_byte_in        = res_byte_ff;
      res_valid_in       = res_valid_ff;
      res_end_in         = res_end_ff;
      res_acc_in         = res_acc_ff;
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff;
      drop_n             = 2'd0;
      mem_we             = 1'b0;
      mem_waddr          = write_cursor_ff;
      mem_wdata          = q_item.data;
      mem_re             = 1'b0;
      mem_raddr          = read_tail_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               res_byte_in  = '0;
               res_valid_in = 1'b0;
               res_end_in   = 1'b0;
               res_acc_in   = 1'b0;
               state_in     = ST_RESP;
               case (q_item.op)
                  OP_OPEN: begin
                     // abandoning an unfinished accepted record costs a drop
                     drop_n             = {1'b0, write_open_ff && !write_discard_ff};
                     write_open_in      = 1'b0;
                     write_discard_in   = 1'b0;
                     write_remaining_in = '0;
                     if (reject) begin
                        drop_n = drop_n + 2'd1;
                        if (q_item.len != '0) begin
                           write_open_in      = 1'b1;
                           write_discard_in   = 1'b1;
                           write_remaining_in = q_item.len;
                        end
                     end else begin
                        write_cursor_in    = write_head_ff;
                        write_remaining_in = q_item.len;
                        write_open_in      = 1'b1;
                        res_acc_in         = 1'b1;
                        cnt_in             = '0;
                        state_in           = ST_OPEN_HDR;
                     end
                  end
                  OP_PAYLOAD: begin
                     if (write_open_ff) begin
                        if (!write_discard_ff) begin
                           mem_we          = 1'b1;
                           write_cursor_in = cursor_next;
                           res_acc_in      = 1'b1;
                        end
                        write_remaining_in = rem_dec;
                        if (rem_dec == '0) begin
                           if (!write_discard_ff) begin
                              write_head_in = cursor_next;
                              if (cursor_next == read_tail_ff) begin
                                 ring_full_in = 1'b1;
                              end
                           end
                           write_open_in    = 1'b0;
                           write_discard_in = 1'b0;
                        end
                     end
                  end
                  OP_TAKE: begin
                     if (read_remaining_ff != '0) begin
                        mem_re            = 1'b1;
                        read_tail_in      = next_pos(read_tail_ff);
                        ring_full_in      = 1'b0;
                        read_remaining_in = rr_dec;
                        res_end_in        = (rr_dec == '0);
                        state_in          = ST_TAKE_WAIT;
                     end else if (used != '0) begin
                        cnt_in   = '0;
                        state_in = ST_HDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OPEN_HDR: begin
            // little-endian length header, one byte a cycle
            mem_we          = 1'b1;
            mem_wdata       = BYTE_W'(hdr_word >> (cnt_ff * BYTE_W));
            write_cursor_in = cursor_next;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(HDR_BYTES - 1)) begin
               state_in = ST_RESP;
            end
         end
         ST_HDR: begin
            // issue reads and collect the previous one, first byte ends lowest
            if (cnt_ff != '0) begin
               hl_in = {rd_data_ff, hl_ff[HDR_W-1:BYTE_W]};
            end
            if (cnt_ff != CNT_W'(HDR_BYTES)) begin
               mem_re       = 1'b1;
               read_tail_in = next_pos(read_tail_ff);
               ring_full_in = 1'b0;
               cnt_in       = cnt_ff + 1'b1;
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if ((hl_ff == '0) || (hl_ff > HDR_W'(RING_BYTES))) begin
               // corrupt header: empty the ring
               drop_n       = 2'd1;
               read_tail_in = write_head_ff;
               ring_full_in = 1'b0;
               state_in     = ST_RESP;
            end else begin
               mem_re            = 1'b1;
               read_tail_in      = next_pos(read_tail_ff);
               ring_full_in      = 1'b0;
               read_remaining_in = hl_ff[CW-1:0] - 1'b1;
               res_end_in        = (hl_ff == HDR_W'(1));
               state_in          = ST_TAKE_WAIT;
            end
         end
         ST_TAKE_WAIT: begin
            res_byte_in  = rd_data_ff;
            res_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.out_byte   = res_byte_ff;
               rsp_in.byte_valid = res_valid_ff;
               rsp_in.record_end = res_end_ff;
               rsp_in.accepted   = res_acc_ff;
               rsp_in.drop_count = drops_ff;
               rsp_in.bytes_used = USED_W'(used);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      drop_sum = {1'b0, drops_ff} + (DROP_W + 1)'(drop_n);
      drops_in = drop_sum[DROP_W] ? DROP_MAX : drop_sum[DROP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      hl_ff       <= hl_in;
      res_byte_ff <= res_byte_in;
      res_end_ff  <= res_end_in;
      res_acc_ff  <= res_acc_in;
      res_valid_ff <= res_valid_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff           <= ST_IDLE;
         write_head_ff      <= '0;
         read_tail_ff       <= '0;
         ring_full_ff       <= 1'b0;
         write_cursor_ff    <= '0;
         write_remaining_ff <= '0;
         write_open_ff      <= 1'b0;
         write_discard_ff   <= 1'b0;
         read_remaining_ff  <= '0;
         drops_ff           <= '0;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         write_head_ff      <= write_head_in;
         read_tail_ff       <= read_tail_in;
         ring_full_ff       <= ring_full_in;
         write_cursor_ff    <= write_cursor_in;
         write_remaining_ff <= write_remaining_in;
         write_open_ff      <= write_open_in;
         write_discard_ff   <= write_discard_in;
         read_remaining_ff  <= read_remaining_in;
         drops_ff           <= drops_in;
         cnt_ff             <= cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   a_discard_open: assert property (@(posedge clock) disable iff (reset)
      write_discard_ff |-> write_open_ff)
      else $error("discard mode without open record");

   a_full_aligned: assert property (@(posedge clock) disable iff (reset)
      ring_full_ff |-> (write_head_ff == read_tail_ff))
      else $error("ring full with pointers apart");

   a_hdr_between_records: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HDR) |-> (read_remaining_ff == '0))
      else $error("header fetch inside a record");

endmodule

// File: tb/framed_ring_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the framed byte ring buffer, predicts each response
// from the requests it sees and compares them in order.
module framed_ring_checker import fbrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    mismatches,
   output int                    pending,
   output int                    used_now,
   output int                    peak_used,
   output int                    checked,
   output int                    bytes_out,
   output int                    commits,
   output logic [DROP_W-1:0]     drop_cnt
);

   localparam int RING     = DEFAULT_RING_BYTES;
   localparam int POS_W    = $clog2(RING);
   localparam int ACC_BIT  = BYTE_W;
   localparam int DROP_LSB = BYTE_W + 1;
   localparam int USED_LSB = DROP_LSB + DROP_W;

   logic [BYTE_W-1:0] ring_mem [RING];
   logic [POS_W-1:0]  wr_head, rd_tail, wr_cursor;
   logic              full_flag, wr_open, wr_discard;
   logic [LEN_W-1:0]  wr_left, rd_left;

   result_type        due_results[$];

   function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
      return (int'(p) == RING - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic int committed_bytes();
      if (full_flag) return RING;
      if (wr_head >= rd_tail) return int'(wr_head) - int'(rd_tail);
      return RING - (int'(rd_tail) - int'(wr_head));
   endfunction

   function automatic void bump_drops();
      if (drop_cnt != DROP_MAX) drop_cnt = drop_cnt + 1'b1;
   endfunction

   function automatic logic [BYTE_W-1:0] pop_byte();
      logic [BYTE_W-1:0] b;
      b = ring_mem[rd_tail];
      rd_tail = wrap_inc(rd_tail);
      full_flag = 1'b0;
      return b;
   endfunction

   // One request through the ring: updates the shadow state, returns the response.
   function automatic result_type ring_buffer_step(input op_type op,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [BYTE_W-1:0] data);
      result_type       r;
      int               ln;
      logic [HDR_W-1:0] hdr;
      logic [POS_W-1:0] p;
      logic             ok;
      r  = '0;
      ln = int'(len);
      case (op)
         OP_OPEN: begin
            // an unfinished stored record is abandoned; a discarded one just ends
            if (wr_open && !wr_discard) bump_drops();
            wr_open    = 1'b0;
            wr_discard = 1'b0;
            wr_left    = '0;
            if (ln == 0 || ln + HDR_BYTES > RING ||
                ln + HDR_BYTES > RING - committed_bytes()) begin
               bump_drops();
               if (ln != 0) begin
                  wr_open    = 1'b1;
                  wr_discard = 1'b1;
                  wr_left    = len;
               end
            end else begin
               p = wr_head;
               for (int i = 0; i < HDR_BYTES; i++) begin
                  ring_mem[p] = BYTE_W'(ln >> (BYTE_W * i));
                  p = wrap_inc(p);
               end
               wr_cursor  = p;
               wr_left    = len;
               wr_open    = 1'b1;
               r.accepted = 1'b1;
            end
         end
         OP_PAYLOAD: begin
            if (wr_open) begin
               if (!wr_discard) begin
                  ring_mem[wr_cursor] = data;
                  wr_cursor  = wrap_inc(wr_cursor);
                  r.accepted = 1'b1;
               end
               if (wr_left != 0) wr_left = wr_left - 1'b1;
               if (wr_left == 0) begin
                  if (!wr_discard) begin
                     wr_head = wr_cursor;
                     if (wr_head == rd_tail) full_flag = 1'b1;
                     commits++;
                  end
                  wr_open    = 1'b0;
                  wr_discard = 1'b0;
               end
            end
         end
         OP_TAKE: begin
            ok = 1'b1;
            if (rd_left == 0) begin
               if (committed_bytes() == 0) begin
                  ok = 1'b0;
               end else begin
                  hdr = '0;
                  for (int i = 0; i < HDR_BYTES; i++) hdr[BYTE_W*i +: BYTE_W] = pop_byte();
                  if (hdr == 0 || hdr > RING) begin
                     // corrupt header: flush everything committed
                     bump_drops();
                     rd_tail   = wr_head;
                     full_flag = 1'b0;
                     ok        = 1'b0;
                  end else begin
                     rd_left = LEN_W'(hdr);
                  end
               end
            end
            if (ok) begin
               r.out_byte   = pop_byte();
               rd_left      = rd_left - 1'b1;
               r.byte_valid = 1'b1;
               r.record_end = (rd_left == 0);
               bytes_out++;
            end
         end
         default: ;
      endcase
      r.drop_count = drop_cnt;
      r.bytes_used = USED_W'(committed_bytes());
      return r;
   endfunction

   always @(posedge clock) begin : check_edge
      result_type got;
      result_type want;
      if (reset) begin
         foreach (ring_mem[i]) ring_mem[i] = '0;
         wr_head    = '0;
         rd_tail    = '0;
         wr_cursor  = '0;
         full_flag  = 1'b0;
         wr_open    = 1'b0;
         wr_discard = 1'b0;
         wr_left    = '0;
         rd_left    = '0;
         drop_cnt   = '0;
         mismatches = 0;
         checked    = 0;
         bytes_out  = 0;
         commits    = 0;
         peak_used  = 0;
         due_results.delete();
      end else begin
         // responses first: a response never belongs to a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte   = rsp_tdata[BYTE_W-1:0];
            got.accepted   = rsp_tdata[ACC_BIT];
            got.drop_count = rsp_tdata[DROP_LSB +: DROP_W];
            got.bytes_used = rsp_tdata[USED_LSB +: USED_W];
            got.byte_valid = rsp_tuser;
            got.record_end = rsp_tlast;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request waiting: byte=%02h valid=%0b",
                           $realtime, got.out_byte, got.byte_valid);
            end else begin
               want = due_results.pop_front();
               checked++;
               if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                   got.record_end !== want.record_end || got.accepted !== want.accepted ||
                   got.drop_count !== want.drop_count ||
                   got.bytes_used !== want.bytes_used) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch on response %0d", $realtime, checked);
                     $display("   expected byte=%02h valid=%0b end=%0b acc=%0b drops=%0d used=%0d",
                              want.out_byte, want.byte_valid, want.record_end,
                              want.accepted, want.drop_count, want.bytes_used);
                     $display("   actual   byte=%02h valid=%0b end=%0b acc=%0b drops=%0d used=%0d",
                              got.out_byte, got.byte_valid, got.record_end,
                              got.accepted, got.drop_count, got.bytes_used);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            due_results.push_back(ring_buffer_step(op_type'(req_tuser),
                                                   req_tdata[LEN_W-1:0],
                                                   req_tdata[LEN_W +: BYTE_W]));
      end
      pending  = due_results.size();
      used_now = committed_bytes();
      if (used_now > peak_used) peak_used = used_now;
   end

endmodule

// File: tb/tb_framed_byte_ring_buffer_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the framed byte ring buffer; all checking lives
// in framed_ring_checker.
module tb_framed_byte_ring_buffer_unit import fbrb_pkg::*; ();

   localparam int RING = DEFAULT_RING_BYTES;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // record_length, data_byte, zero pad
   logic [KIND_W-1:0]     req_tuser  = '0;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // out_byte, accepted, drop_count, bytes_used
   logic                  rsp_tuser;         // byte_valid
   logic                  rsp_tlast;         // record_end

   int                    mismatches, pending, used_now, peak_used;
   int                    checked, bytes_out, commits;
   logic [DROP_W-1:0]     drop_cnt;

   // idle odds in percent per cycle, changed between phases
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    requests_sent = 0;
   int                    useful_items  = 0;   // opens, in-record payloads, takes

   framed_byte_ring_buffer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   framed_ring_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending),
      .used_now   (used_now),
      .peak_used  (peak_used),
      .checked    (checked),
      .bytes_out  (bytes_out),
      .commits    (commits),
      .drop_cnt   (drop_cnt)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("status: fail");
      $finish;
   end

   // Called on a falling edge; returns on the falling edge after acceptance, with
   // valid still high so the next request can follow without a bubble.
   task automatic put_request(input op_type op, input int len, input int data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({BYTE_W'(data), LEN_W'(len)});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // Open plus payload; cut_short leaves the record unfinished so the next open
   // abandons it. Length and data fields not used by a kind carry random bits.
   task automatic send_record(input int len, input bit cut_short);
      int n;
      n = cut_short ? $urandom_range(len - 1) : len;
      put_request(OP_OPEN, len, $urandom_range(255));
      useful_items++;
      repeat (n) begin
         put_request(OP_PAYLOAD, $urandom_range(2047), $urandom_range(255));
         useful_items++;
      end
   endtask

   task automatic send_takes(input int n);
      repeat (n) begin
         put_request(OP_TAKE, $urandom_range(2047), $urandom_range(255));
         useful_items++;
      end
   endtask

   // Hold the request side until every response is back and the back end is quiet.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Mostly well-formed records and take bursts; the rest is raw noise of any kind
   // and length (over-long opens, stray payloads, unknown kind).
   task automatic run_traffic(input int n_items, input int rec_pct, input int take_pct);
      int     start;
      int     roll;
      int     len;
      op_type k;
      start = useful_items;
      while (useful_items - start < n_items) begin
         roll = $urandom_range(99);
         if (roll < rec_pct) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
            send_record(len, (len > 1) && ($urandom_range(99) < 8));
         end else if (roll < rec_pct + take_pct) begin
            send_takes($urandom_range(1, 16));
         end else begin
            k = op_type'($urandom_range(3));
            put_request(k, $urandom_range(2047), $urandom_range(255));
            if (k == OP_OPEN || k == OP_TAKE) useful_items++;
         end
      end
   endtask

   // Top the ring up to exactly full with short records (most bytes come from
   // headers, so few requests), bounce an open off the full ring, then read a
   // little back. Needs the exact fill level, so it starts drained; less than
   // five bytes of room cannot be filled exactly and is left as is.
   task automatic fill_and_drain();
      int room;
      wait_drained();
      room = RING - used_now;
      while (room > 3 * HDR_BYTES + 1) begin
         send_record(1, 1'b0);
         room = room - (HDR_BYTES + 1);
      end
      if (room > HDR_BYTES) send_record(room - HDR_BYTES, 1'b0);
      send_record(1, 1'b0);        // no room left: rejected, its byte discarded
      wait_drained();
      send_takes(48);
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 81;

      // directed: empty ring, stray requests, rejected opens and discard mode
      put_request(OP_TAKE, 0, 0);            // nothing committed
      put_request(OP_PAYLOAD, 0, 8'h11);     // no record open
      put_request(OP_NONE, 2047, 8'hFF);     // unknown kind
      put_request(OP_OPEN, 0, 0);            // zero length
      put_request(OP_OPEN, RING - HDR_BYTES + 1, 0);   // record plus header too big
      put_request(OP_PAYLOAD, 0, 8'h22);     // swallowed
      put_request(OP_PAYLOAD, 0, 8'h33);
      put_request(OP_OPEN, 2047, 0);         // ends discard quietly, rejected again
      // accepted open ends the discarded record without a second drop
      put_request(OP_OPEN, 3, 0);
      put_request(OP_PAYLOAD, 0, 8'h00);
      put_request(OP_PAYLOAD, 0, 8'hFF);
      put_request(OP_OPEN, 2, 0);            // abandons the unfinished record
      put_request(OP_PAYLOAD, 0, 8'hA5);
      put_request(OP_PAYLOAD, 0, 8'h5A);     // commits
      put_request(OP_TAKE, 0, 0);            // header fetch plus first byte
      put_request(OP_TAKE, 0, 0);            // last byte of record
      put_request(OP_TAKE, 0, 0);            // empty again
      put_request(OP_OPEN, 1, 0);            // single-byte record
      put_request(OP_PAYLOAD, 0, 8'h3C);
      put_request(OP_TAKE, 0, 0);

      // phase 1: slow-ish sender, heavily stalled receiver, write-heavy mix
      run_traffic(130, 60, 25);
      fill_and_drain();

      // phase 2: roles swapped, read-heavy mix
      send_idle_pct = 81;
      recv_idle_pct = 28;
      run_traffic(130, 35, 50);

      // phase 3: full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_traffic(130, 45, 40);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);

      $display("covered %0d requests and %0d checked responses: %0d records committed,",
               requests_sent, checked, commits);
      $display("%0d payload bytes read back, %0d drops counted, ring peak %0d of %0d bytes",
               bytes_out, drop_cnt, peak_used, RING);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: framed_byte_ring_buffer_unit.f
sv/fbrb_pkg.sv
sv/fbrb_front.sv
sv/fbrb_back.sv
sv/framed_byte_ring_buffer_unit.sv
tb/framed_ring_checker.sv
tb/tb_framed_byte_ring_buffer_unit.sv
